/* hdl/ihex_pkg.sv */
package ihex_pkg;

	// Default for the data buffer depth (upper bound of its range is 64)
	localparam int MAX_DATA_BYTES_DEF = 32;

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Record types
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ELA  = 8'h04;

	// Result status codes
	localparam logic [3:0] ST_DATA_BYTE   = 4'd0;
	localparam logic [3:0] ST_EMPTY_DATA  = 4'd1;
	localparam logic [3:0] ST_EOF_OK      = 4'd2;
	localparam logic [3:0] ST_UNHANDLED   = 4'd3;
	localparam logic [3:0] ST_NO_START    = 4'd4;
	localparam logic [3:0] ST_BAD_HEX     = 4'd5;
	localparam logic [3:0] ST_EARLY_EOL   = 4'd6;
	localparam logic [3:0] ST_EARLY_END   = 4'd7;
	localparam logic [3:0] ST_BAD_CKSUM   = 4'd8;
	localparam logic [3:0] ST_TOO_LONG    = 4'd9;
	localparam logic [3:0] ST_BAD_ELA_LEN = 4'd10;
	localparam logic [3:0] ST_EOF_DATA    = 4'd11;
	localparam logic [3:0] ST_EOF_NOTLAST = 4'd12;

	// One unit of work for the back end: either a single result or a burst
	// of data bytes read from the record buffer.
	typedef struct packed {
		logic        burst;
		logic [3:0]  status;
		logic [7:0]  rec_type;
		logic [31:0] addr;
		logic [7:0]  count;
	} job_t;

	// {valid, nibble value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

/* hdl/ihex_front.sv */
module ihex_front
	import ihex_pkg::*;
#(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
	parameter int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_char,
	input  logic          q_full,
	output logic          push,
	output job_t          push_job,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	input  logic          burst_done
);

	localparam int CNT_W = $clog2(MAX_DATA_BYTES + 1);

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_COUNT   = 3'd1;
	localparam logic [2:0] PH_ADDR    = 3'd2;
	localparam logic [2:0] PH_TYPE    = 3'd3;
	localparam logic [2:0] PH_DATA    = 3'd4;
	localparam logic [2:0] PH_CKSUM   = 3'd5;
	localparam logic [2:0] PH_GAP     = 3'd6;
	localparam logic [2:0] PH_EOFWAIT = 3'd7;

	logic [2:0]       phase_q, phase_d;
	logic [3:0]       hi_nib_q, hi_nib_d;
	logic             nib_sel_q, nib_sel_d;
	logic [CNT_W-1:0] fpos_q, fpos_d;
	logic [CNT_W-1:0] len_q, len_d;
	logic [15:0]      offs_q, offs_d;
	logic [7:0]       kind_q, kind_d;
	logic [7:0]       csum_q, csum_d;
	logic [15:0]      upper_q, upper_d;
	logic [7:0]       b0_q, b0_d;
	logic [7:0]       b1_q, b1_d;
	logic             halted_q, halted_d;
	logic [1:0]       pend_q;

	logic       acc, eol;
	logic [4:0] hv;
	logic [7:0] b;
	logic [7:0] sum;

	function automatic job_t single(input logic [3:0] st, input logic [7:0] ty,
			input logic [31:0] ad);
		job_t j;
		j = '0;
		j.status   = st;
		j.rec_type = ty;
		j.addr     = ad;
		j.count    = 8'd1;
		return j;
	endfunction

	// data bytes may not land in the buffer while an earlier burst still reads it
	assign in_stall = q_full || (phase_q == PH_DATA && pend_q != 2'd0);
	assign acc      = in_valid && !in_stall;
	assign eol      = (in_char == CH_CR) || (in_char == CH_LF);
	assign hv       = hex_value(in_char);
	assign b        = {hi_nib_q, hv[3:0]};
	assign sum      = csum_q + b;

	always_comb begin
		phase_d   = phase_q;
		hi_nib_d  = hi_nib_q;
		nib_sel_d = nib_sel_q;
		fpos_d    = fpos_q;
		len_d     = len_q;
		offs_d    = offs_q;
		kind_d    = kind_q;
		csum_d    = csum_q;
		upper_d   = upper_q;
		b0_d      = b0_q;
		b1_d      = b1_q;
		halted_d  = halted_q;
		push      = 1'b0;
		push_job  = '0;
		wr_en     = 1'b0;
		wr_addr   = fpos_q[AW-1:0];
		wr_data   = b;
		if (acc && !halted_q) begin
			unique case (phase_q)
				PH_START, PH_GAP: begin
					if (!(phase_q == PH_GAP && eol)) begin
						if (in_char != CH_COLON) begin
							push     = 1'b1;
							push_job = single(ST_NO_START, REC_DATA, 32'd0);
							halted_d = 1'b1;
						end else begin
							csum_d    = 8'd0;
							nib_sel_d = 1'b0;
							fpos_d    = '0;
							phase_d   = PH_COUNT;
						end
					end
				end
				PH_EOFWAIT: begin
					if (!eol) begin
						push     = 1'b1;
						push_job = single((in_char == CH_NUL) ? ST_EOF_OK : ST_EOF_NOTLAST,
							REC_EOF, 32'd0);
						halted_d = 1'b1;
					end
				end
				default: begin
					if (!hv[4]) begin
						push     = 1'b1;
						push_job = single(eol ? ST_EARLY_EOL :
							((in_char == CH_NUL) ? ST_EARLY_END : ST_BAD_HEX),
							REC_DATA, 32'd0);
						halted_d = 1'b1;
					end else if (!nib_sel_q) begin
						hi_nib_d  = hv[3:0];
						nib_sel_d = 1'b1;
					end else begin
						nib_sel_d = 1'b0;
						csum_d    = sum;
						unique case (phase_q)
							PH_COUNT: begin
								if (b > 8'(MAX_DATA_BYTES)) begin
									push     = 1'b1;
									push_job = single(ST_TOO_LONG, REC_DATA, 32'd0);
									halted_d = 1'b1;
								end else begin
									len_d   = CNT_W'(b);
									fpos_d  = '0;
									phase_d = PH_ADDR;
								end
							end
							PH_ADDR: begin
								if (fpos_q == '0) begin
									offs_d = {b, 8'd0};
									fpos_d = CNT_W'(1);
								end else begin
									offs_d  = {offs_q[15:8], b};
									phase_d = PH_TYPE;
								end
							end
							PH_TYPE: begin
								kind_d  = b;
								fpos_d  = '0;
								phase_d = (len_q != '0) ? PH_DATA : PH_CKSUM;
							end
							PH_DATA: begin
								wr_en  = 1'b1;
								fpos_d = fpos_q + CNT_W'(1);
								if (fpos_q == '0) begin
									b0_d = b;
								end
								if (fpos_q == CNT_W'(1)) begin
									b1_d = b;
								end
								if (fpos_d >= len_q) begin
									phase_d = PH_CKSUM;
								end
							end
							default: begin
								phase_d = PH_GAP;
								if (sum != 8'd0) begin
									push     = 1'b1;
									push_job = single(ST_BAD_CKSUM, kind_q, 32'd0);
									halted_d = 1'b1;
								end else begin
									unique case (kind_q)
										REC_DATA: begin
											push = 1'b1;
											if (len_q == '0) begin
												push_job = single(ST_EMPTY_DATA, REC_DATA,
													{upper_q, offs_q});
											end else begin
												push_job = single(ST_DATA_BYTE, REC_DATA,
													{upper_q, offs_q});
												push_job.burst = 1'b1;
												push_job.count = 8'(len_q);
											end
										end
										REC_EOF: begin
											if (len_q != '0) begin
												push     = 1'b1;
												push_job = single(ST_EOF_DATA, REC_EOF, 32'd0);
												halted_d = 1'b1;
											end else begin
												phase_d = PH_EOFWAIT;
											end
										end
										REC_ELA: begin
											if (len_q != CNT_W'(2)) begin
												push     = 1'b1;
												push_job = single(ST_BAD_ELA_LEN, REC_ELA, 32'd0);
												halted_d = 1'b1;
											end else begin
												upper_d = {b0_q, b1_q};
											end
										end
										default: begin
											push     = 1'b1;
											push_job = single(ST_UNHANDLED, kind_q, 32'd0);
										end
									endcase
								end
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			hi_nib_q  <= 4'd0;
			nib_sel_q <= 1'b0;
			fpos_q    <= '0;
			len_q     <= '0;
			offs_q    <= 16'd0;
			kind_q    <= 8'd0;
			csum_q    <= 8'd0;
			upper_q   <= 16'd0;
			b0_q      <= 8'd0;
			b1_q      <= 8'd0;
			halted_q  <= 1'b0;
			pend_q    <= 2'd0;
		end else begin
			phase_q   <= phase_d;
			hi_nib_q  <= hi_nib_d;
			nib_sel_q <= nib_sel_d;
			fpos_q    <= fpos_d;
			len_q     <= len_d;
			offs_q    <= offs_d;
			kind_q    <= kind_d;
			csum_q    <= csum_d;
			upper_q   <= upper_d;
			b0_q      <= b0_d;
			b1_q      <= b1_d;
			halted_q  <= halted_d;
			pend_q    <= pend_q + 2'((push && push_job.burst) ? 1 : 0) - 2'(burst_done ? 1 : 0);
		end
	end

endmodule

/* hdl/ihex_queue.sv */
module ihex_queue
	import ihex_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push ? 1 : 0) - 2'(pop ? 1 : 0);
		end
	end

endmodule

/* hdl/ihex_back.sv */
module ihex_back
	import ihex_pkg::*;
#(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF,
	parameter int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          q_empty,
	input  job_t          q_head,
	output logic          pop,
	output logic          burst_done,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [3:0]    status,
	output logic [31:0]   record_address,
	output logic [5:0]    byte_offset,
	output logic [7:0]    data_byte,
	output logic [7:0]    record_type,
	output logic          last
);

	logic [7:0] buf_mem [MAX_DATA_BYTES];

	job_t       job_q;
	logic       busy_q;
	logic [5:0] idx_q;
	logic       valid_q;
	logic [3:0] status_q;
	logic [31:0] addr_q;
	logic [5:0] offs_q;
	logic [7:0] data_q;
	logic [7:0] type_q;
	logic       last_q;

	logic load, emit, fin;

	assign load       = !valid_q || !out_stall;
	assign emit       = busy_q && load;
	assign fin        = !job_q.burst || ({2'b00, idx_q} == job_q.count - 8'd1);
	assign pop        = !busy_q && !q_empty;
	assign burst_done = emit && fin && job_q.burst;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
	end

	// output beat; data byte comes straight from the buffer (registered read)
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= job_q.status;
			addr_q   <= job_q.addr;
			offs_q   <= job_q.burst ? idx_q : 6'd0;
			data_q   <= job_q.burst ? buf_mem[idx_q[AW-1:0]] : 8'd0;
			type_q   <= job_q.rec_type;
			last_q   <= fin;
		end
		if (pop) begin
			job_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 6'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 6'd0;
			end else if (emit) begin
				if (fin) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
			if (load) begin
				valid_q <= emit;
			end
		end
	end

	assign out_valid      = valid_q;
	assign status         = status_q;
	assign record_address = addr_q;
	assign byte_offset    = offs_q;
	assign data_byte      = data_q;
	assign record_type    = type_q;
	assign last           = last_q;

endmodule

/* hdl/intel_hex_record_parser_top.sv */
// Intel HEX record parser. Takes the hex text one character per input beat
// (character 0 marks end of input) and returns result beats: one per data
// byte of each verified data record, a marker for an empty data record, a
// warning for an unhandled record type, an end-of-file confirmation, or one
// fatal error status. A fatal error or a confirmed end of file halts the
// block until reset; later input beats are taken and ignored. Input: one
// character per cycle unless held off. The front end holds off any
// character (in_stall) while the two-entry job queue is full, and holds off a
// data character of a new record while bytes of the previous data record are
// still being read out of the single record buffer. A job passes from the
// taken character through the queue, the sequencer's job register and the
// result register; the back end then gives one result beat per cycle while
// out_stall is low, with a gap between jobs while the next job is popped.
// The result register lets a new character be taken while a finished beat
// waits on out_stall.
module intel_hex_record_parser_top
	import ihex_pkg::*;
#(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// character channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_char,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [31:0] record_address,
	output logic [5:0]  byte_offset,
	output logic [7:0]  data_byte,
	output logic [7:0]  record_type,
	output logic        last
);

	// record buffer address width
	localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

	logic          push, pop, q_full, q_empty, burst_done;
	job_t          push_job, q_head;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	// character parser, checksum and record checks
	ihex_front #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES),
		.AW(AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_char   (in_char),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.burst_done(burst_done)
	);

	// pending result jobs
	ihex_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (q_head)
	);

	// result sequencer with the record buffer
	ihex_back #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES),
		.AW(AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (pop),
		.burst_done    (burst_done),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.record_address(record_address),
		.byte_offset   (byte_offset),
		.data_byte     (data_byte),
		.record_type   (record_type),
		.last          (last)
	);

endmodule

/* bench/tb_intel_hex_record_parser_top.sv */
// Bench for the Intel HEX record parser.
// Characters go in one beat at a time; a behavioural parser in this module
// follows the same text and queues the result beats it expects. Every beat
// that leaves the block is compared with the oldest queued one.
// The block halts for good on any fatal status or a confirmed end of file.
// Reset is applied only once, so all clean records come first and a single
// randomly chosen fatal ending closes the run. Each seed draws its
// ending at random. Further characters then check that a halted block stays quiet.
module tb_intel_hex_record_parser_top;
	import ihex_pkg::*;

	localparam int MAX_BYTES   = MAX_DATA_BYTES_DEF;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int DRAIN_WAIT  = 64;	// a full buffer drain plus the job queue
	localparam int SHOW_LIMIT  = 10;

	localparam logic [7:0] CH_DIGIT0  = "0";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_LOWER_A = "a";

	// where the tracking parser stands in the text
	typedef enum logic [2:0] {
		WAIT_COLON, GET_COUNT, GET_OFFSET, GET_TYPE, GET_DATA, GET_SUM,
		BETWEEN, AFTER_EOF
	} hex_phase_e;

	// how the run is closed; one is drawn per seed
	typedef enum int {
		END_EOF_OK, END_EOF_NOT_LAST, END_EOF_DATA, END_BAD_ELA, END_BAD_SUM,
		END_TOO_LONG, END_BAD_HEX, END_EARLY_EOL, END_EARLY_NUL, END_NO_START,
		END_COUNT
	} ending_e;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] addr;
		logic [5:0]  offset;
		logic [7:0]  data;
		logic [7:0]  rtype;
		logic        last;
	} result_beat_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  in_char   = CH_NUL;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  status;
	logic [31:0] record_address;
	logic [5:0]  byte_offset;
	logic [7:0]  data_byte;
	logic [7:0]  record_type;
	logic        last;

	// beats the block still owes us, oldest first
	result_beat_t due_beats[$];

	// tracking parser state
	hex_phase_e  p_phase;
	logic [3:0]  p_high;
	logic        p_nsel;
	logic [7:0]  p_pos;
	logic [7:0]  p_len;
	logic [15:0] p_off;
	logic [7:0]  p_kind;
	logic [7:0]  p_sum;
	logic [15:0] p_base;
	logic [7:0]  p_buf [MAX_BYTES];
	logic        p_halted;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int chars_sent     = 0;
	int records_sent   = 0;
	int beats_checked  = 0;
	int ignored_chars  = 0;
	int failures       = 0;
	int cycle_count    = 0;
	ending_e ending;

	intel_hex_record_parser_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_char        (in_char),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.record_address (record_address),
		.byte_offset    (byte_offset),
		.data_byte      (data_byte),
		.record_type    (record_type),
		.last           (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d beats still due",
				cycle_count, due_beats.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void log_failure(input string what, input result_beat_t want,
			input result_beat_t got);
		failures++;
		if (failures <= SHOW_LIMIT) begin
			$display("%s: expected st=%0d addr=%h off=%0d data=%h type=%h last=%b",
				what, want.status, want.addr, want.offset, want.data, want.rtype, want.last);
			$display("    got      st=%0d addr=%h off=%0d data=%h type=%h last=%b",
				got.status, got.addr, got.offset, got.data, got.rtype, got.last);
		end
	endfunction

	// Outputs and out_stall only move at the rising edge, so what is seen at
	// the falling edge is exactly what the next rising edge will take.
	always @(negedge clk) begin
		result_beat_t got;
		result_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, record_address, byte_offset, data_byte, record_type, last};
			beats_checked++;
			if (due_beats.size() == 0) begin
				log_failure("unexpected beat", '0, got);
			end else begin
				want = due_beats.pop_front();
				if (got !== want) begin
					log_failure("beat mismatch", want, got);
				end
			end
		end
	end

	function automatic int hex_digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - CH_DIGIT0);
		if (c >= "a" && c <= "f") return int'(c - CH_LOWER_A) + 10;
		if (c >= "A" && c <= "F") return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	// letters come out in either case at random
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_DIGIT0 + 8'(n);
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
	endfunction

	function automatic void owe_beat(input logic [3:0] st, input logic [31:0] addr,
			input logic [5:0] off, input logic [7:0] data, input logic [7:0] rtype,
			input logic lst);
		result_beat_t b;
		b = {st, addr, off, data, rtype, lst};
		due_beats.push_back(b);
	endfunction

	function automatic void halt_with(input logic [3:0] st, input logic [7:0] rtype);
		owe_beat(st, 32'h0, 6'h0, 8'h0, rtype, 1'b1);
		p_halted = 1'b1;
	endfunction

	function automatic void parse_reset();
		p_phase  = WAIT_COLON;
		p_high   = '0;
		p_nsel   = 1'b0;
		p_pos    = '0;
		p_len    = '0;
		p_off    = '0;
		p_kind   = '0;
		p_sum    = '0;
		p_base   = '0;
		p_halted = 1'b0;
	endfunction

	// Follows one accepted character and queues whatever beats it causes.
	function automatic void parse_hex_char(input logic [7:0] c);
		logic        is_eol;
		int          d;
		logic [7:0]  b;
		logic [31:0] addr;
		if (p_halted) return;
		is_eol = (c == CH_CR || c == CH_LF);

		if (p_phase == WAIT_COLON || p_phase == BETWEEN) begin
			// line ends only tolerated once a record has been seen
			if (p_phase == BETWEEN && is_eol) return;
			if (c != CH_COLON) begin
				halt_with(ST_NO_START, 8'h00);
				return;
			end
			p_sum   = '0;
			p_nsel  = 1'b0;
			p_pos   = '0;
			p_phase = GET_COUNT;
			return;
		end
		if (p_phase == AFTER_EOF) begin
			if (is_eol) return;
			halt_with((c == CH_NUL) ? ST_EOF_OK : ST_EOF_NOTLAST, REC_EOF);
			return;
		end

		d = hex_digit_value(c);
		if (d < 0) begin
			halt_with(is_eol ? ST_EARLY_EOL : ((c == CH_NUL) ? ST_EARLY_END : ST_BAD_HEX),
				8'h00);
			return;
		end
		if (!p_nsel) begin
			p_high = d[3:0];
			p_nsel = 1'b1;
			return;
		end
		p_nsel = 1'b0;
		b      = {p_high, d[3:0]};
		p_sum  = p_sum + b;

		case (p_phase)
			GET_COUNT: begin
				p_len = b;
				if (b > MAX_BYTES) begin
					halt_with(ST_TOO_LONG, 8'h00);
				end else begin
					p_pos   = '0;
					p_phase = GET_OFFSET;
				end
			end
			GET_OFFSET: begin
				if (p_pos == 0) begin
					p_off = {b, 8'h00};
					p_pos = 8'd1;
				end else begin
					p_off   = p_off | {8'h00, b};
					p_phase = GET_TYPE;
				end
			end
			GET_TYPE: begin
				p_kind  = b;
				p_pos   = '0;
				p_phase = (p_len != 0) ? GET_DATA : GET_SUM;
			end
			GET_DATA: begin
				if (p_pos < MAX_BYTES) p_buf[p_pos] = b;
				p_pos++;
				if (p_pos >= p_len) p_phase = GET_SUM;
			end
			default: begin
				// checksum byte in: verify first, then act on the type
				addr = {p_base, 16'h0000} + {16'h0000, p_off};
				if (p_sum != 0) begin
					halt_with(ST_BAD_CKSUM, p_kind);
				end else begin
					case (p_kind)
						REC_DATA: begin
							if (p_len == 0) begin
								owe_beat(ST_EMPTY_DATA, addr, 6'h0, 8'h00, REC_DATA, 1'b1);
							end else begin
								for (int i = 0; i < p_len; i++) begin
									owe_beat(ST_DATA_BYTE, addr, 6'(i), p_buf[i], REC_DATA,
										i == p_len - 1);
								end
							end
							p_phase = BETWEEN;
						end
						REC_EOF: begin
							if (p_len != 0) halt_with(ST_EOF_DATA, REC_EOF);
							else p_phase = AFTER_EOF;
						end
						REC_ELA: begin
							if (p_len != 2) begin
								halt_with(ST_BAD_ELA_LEN, REC_ELA);
							end else begin
								p_base  = {p_buf[0], p_buf[1]};
								p_phase = BETWEEN;
							end
						end
						default: begin
							owe_beat(ST_UNHANDLED, 32'h0, 6'h0, 8'h00, p_kind, 1'b1);
							p_phase = BETWEEN;
						end
					endcase
				end
			end
		endcase
	endfunction

	// One character beat. Entered and left just after a rising edge; valid
	// stays high on return so back-to-back beats need no second assignment.
	task automatic send_char(input logic [7:0] c);
		bit taken;
		taken = 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		chars_sent++;
		parse_hex_char(c);
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		foreach (text[i]) send_char(text[i]);
	endtask

	// none, CR, LF, CRLF or a blank line between records
	task automatic send_eol();
		case ($urandom_range(0, 4))
			1: send_char(CH_CR);
			2: send_char(CH_LF);
			3: begin
				send_char(CH_CR);
				send_char(CH_LF);
			end
			4: begin
				send_char(CH_LF);
				send_char(CH_LF);
			end
			default: ;
		endcase
	endtask

	// Builds ':' count offset type payload checksum as hex text. The count
	// field is taken as given, so it may disagree with the payload.
	task automatic make_record(input logic [7:0] kind, input logic [7:0] count,
			input logic [15:0] offset, input logic [7:0] payload[$], input bit bad_sum,
			output logic [7:0] text[$]);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		bytes.push_back(count);
		bytes.push_back(offset[15:8]);
		bytes.push_back(offset[7:0]);
		bytes.push_back(kind);
		foreach (payload[i]) bytes.push_back(payload[i]);
		sum = '0;
		foreach (bytes[i]) sum = sum + bytes[i];
		sum = -sum;
		if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
		bytes.push_back(sum);
		text.delete();
		text.push_back(CH_COLON);
		foreach (bytes[i]) begin
			text.push_back(hex_char(bytes[i][7:4]));
			text.push_back(hex_char(bytes[i][3:0]));
		end
	endtask

	task automatic send_record(input logic [7:0] kind, input logic [15:0] offset,
			input logic [7:0] payload[$]);
		logic [7:0] text[$];
		make_record(kind, 8'(payload.size()), offset, payload, 1'b0, text);
		send_text(text);
		records_sent++;
	endtask

	// Extremes of offset, base, type and data, with no idling at all.
	task automatic test_directed_records();
		logic [7:0] payload[$];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// empty data record at the top offset, first character of the run
		send_record(REC_DATA, 16'hFFFF, payload);
		send_char(CH_CR);
		send_char(CH_LF);
		// base all ones, so the next data lands at the very top of memory
		payload = '{8'hFF, 8'hFF};
		send_record(REC_ELA, 16'h0000, payload);
		send_char(CH_LF);
		payload = '{8'hFF, 8'h00};
		send_record(REC_DATA, 16'hFFFF, payload);
		// unhandled type at both ends of the type range, straight after
		payload.delete();
		send_record(8'hFF, 16'h0000, payload);
		payload = '{8'h5A};
		send_record(8'h02, 16'h8000, payload);
		send_char(CH_CR);
		payload = '{8'h00, 8'h00};
		send_record(REC_ELA, 16'h1234, payload);
	endtask

	// Well-formed records with random content under one idling mix.
	task automatic test_random_records(input int idle_pct, input int stall_pct,
			input int char_budget);
		int         first;
		int         pick;
		logic [7:0] kind;
		int         len;
		logic [7:0] payload[$];
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first          = chars_sent;
		while (chars_sent - first < char_budget) begin
			pick = $urandom_range(0, 99);
			payload.delete();
			if (pick < 70) begin
				kind = REC_DATA;
				// mostly short; now and then a full buffer
				len  = (pick < 6) ? MAX_BYTES : ((pick < 15) ? $urandom_range(9, MAX_BYTES)
					: $urandom_range(0, 8));
			end else if (pick < 85) begin
				kind = REC_ELA;
				len  = 2;
			end else begin
				do kind = 8'($urandom_range(0, 255));
				while (kind == REC_DATA || kind == REC_EOF || kind == REC_ELA);
				len = $urandom_range(0, 4);
			end
			repeat (len) payload.push_back(8'($urandom_range(0, 255)));
			send_record(kind, 16'($urandom_range(0, 16'hFFFF)), payload);
			send_eol();
		end
	endtask

	// Sends a data record cut short inside, then the offending character.
	task automatic send_broken_record(input logic [7:0] bad);
		logic [7:0] payload[$];
		logic [7:0] text[$];
		int         cut;
		repeat ($urandom_range(0, 4)) payload.push_back(8'($urandom_range(0, 255)));
		make_record(REC_DATA, 8'(payload.size()), 16'($urandom_range(0, 16'hFFFF)), payload,
			1'b0, text);
		cut = $urandom_range(1, text.size() - 1);
		for (int i = 0; i < cut; i++) send_char(text[i]);
		send_char(bad);
	endtask

	// One fatal ending, drawn at random; the block halts after it.
	task automatic test_fatal_ending();
		logic [7:0] payload[$];
		logic [7:0] text[$];
		logic [7:0] c;
		int         len;
		ending = ending_e'($urandom_range(0, END_COUNT - 1));
		case (ending)
			END_EOF_OK, END_EOF_NOT_LAST: begin
				send_record(REC_EOF, 16'($urandom_range(0, 16'hFFFF)), payload);
				send_eol();
				if (ending == END_EOF_OK) begin
					send_char(CH_NUL);
				end else begin
					do c = 8'($urandom_range(1, 255));
					while (c == CH_CR || c == CH_LF);
					send_char(c);
				end
			end
			END_EOF_DATA: begin
				repeat ($urandom_range(1, 4)) payload.push_back(8'($urandom_range(0, 255)));
				send_record(REC_EOF, 16'h0000, payload);
			end
			END_BAD_ELA: begin
				do len = $urandom_range(0, 6);
				while (len == 2);
				repeat (len) payload.push_back(8'($urandom_range(0, 255)));
				send_record(REC_ELA, 16'h0000, payload);
			end
			END_BAD_SUM: begin
				case ($urandom_range(0, 3))
					0: c = REC_DATA;
					1: c = REC_EOF;
					2: c = REC_ELA;
					default: c = 8'($urandom_range(0, 255));
				endcase
				repeat ($urandom_range(0, 4)) payload.push_back(8'($urandom_range(0, 255)));
				make_record(c, 8'(payload.size()), 16'($urandom_range(0, 16'hFFFF)), payload,
					1'b1, text);
				send_text(text);
			end
			END_TOO_LONG: begin
				// the count alone is enough; the rest is swallowed once halted
				make_record(REC_DATA, 8'($urandom_range(MAX_BYTES + 1, 255)), 16'h0000,
					payload, 1'b0, text);
				send_text(text);
			end
			END_BAD_HEX: begin
				do c = 8'($urandom_range(1, 255));
				while (hex_digit_value(c) >= 0 || c == CH_CR || c == CH_LF);
				send_broken_record(c);
			end
			END_EARLY_EOL: send_broken_record($urandom_range(0, 1) ? CH_CR : CH_LF);
			END_EARLY_NUL: send_broken_record(CH_NUL);
			default: begin
				// something other than a start code between records
				send_eol();
				if ($urandom_range(0, 3) == 0) begin
					c = CH_NUL;
				end else begin
					do c = 8'($urandom_range(1, 255));
					while (c == CH_COLON || c == CH_CR || c == CH_LF);
				end
				send_char(c);
			end
		endcase
	endtask

	// Arbitrary characters of any bit pattern; a halted block must say nothing.
	task automatic test_halted_input();
		repeat (24) begin
			send_char(8'($urandom_range(0, 255)));
			ignored_chars++;
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (due_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		parse_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_records();
		test_random_records(0, 0, 15);
		test_random_records(74, 0, 15);
		test_random_records(0, 74, 15);
		test_random_records(33, 33, 15);
		test_fatal_ending();
		test_halted_input();
		wait_for_drain();

		if (due_beats.size() != 0) begin
			$display("%0d expected beats never arrived", due_beats.size());
			failures += due_beats.size();
		end
		$display("Sent %0d characters in %0d records under four idling mixes; %0d beats checked.",
			chars_sent, records_sent, beats_checked);
		$display("Closing case %s, then %0d characters into the halted block; %0d failures.",
			ending.name(), ignored_chars, failures);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
